// ===== hdl/sos_pkg.sv =====
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types, constants and helpers of the substring occurrence scanner.
// ----------------------------------------------------------------------------
package sos_pkg;

	// pattern and index sizing
	localparam int MAX_PATTERN = 8;
	localparam int INDEX_BITS  = 16;
	localparam int PIDX_W      = $clog2(MAX_PATTERN);
	localparam int WIN_DEPTH   = MAX_PATTERN - 1;
	localparam int LEN_W       = 4;
	localparam int CFG_DATA_W  = 8 * MAX_PATTERN;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_W       = 16;

	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES  = 1'b0,
		CFG_PATTERN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;
	typedef logic [WIN_DEPTH-1:0][7:0] window_t;

	// input word
	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} item_t;

	// result word
	typedef struct packed {
		logic [OUT_W-1:0] match_count;
		logic             found;
		logic [OUT_W-1:0] first_index;
		logic [OUT_W-1:0] last_index;
		logic             saturated;
	} result_t;

	// window compare outcome
	typedef struct packed {
		logic   hit;
		index_t start;
	} match_t;

	// pattern length minus one, clamped to 1..MAX_PATTERN
	function automatic logic [PIDX_W-1:0] eff_len_m1(input logic [LEN_W-1:0] plen);
		logic [PIDX_W-1:0] r;
		if (plen == '0) begin
			r = '0;
		end else if (plen > LEN_W'(MAX_PATTERN)) begin
			r = PIDX_W'(MAX_PATTERN - 1);
		end else begin
			r = PIDX_W'(plen - 1'b1);
		end
		return r;
	endfunction

endpackage

// ===== hdl/sos_match.sv =====
// ----------------------------------------------------------------------------
// sos_match
// Parallel compare of the newest pattern-length characters against the
// configured pattern, with the start index of a hit.
// ----------------------------------------------------------------------------
module sos_match (
	input  sos_pkg::window_t              recent,
	input  logic [7:0]                    ch,
	input  sos_pkg::pattern_t             pattern,
	input  logic [sos_pkg::PIDX_W-1:0]    len_m1,
	input  sos_pkg::index_t               position,
	output sos_pkg::match_t               m
);
	import sos_pkg::*;

	// window after the shift, index 0 is the newest character
	logic [MAX_PATTERN-1:0][7:0] w;
	logic                        all_ok;

	always_comb begin
		w[0] = ch;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			w[k] = recent[k-1];
		end
	end

	// window slot j must equal pattern byte len-1-j for every slot in use
	always_comb begin
		logic [PIDX_W-1:0] pidx;
		all_ok = 1'b1;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pidx = len_m1 - PIDX_W'(j);
			if ((PIDX_W'(j) <= len_m1) && (w[j] != pattern[pidx])) begin
				all_ok = 1'b0;
			end
		end
	end

	// no hit until enough characters have arrived
	always_comb begin
		m.hit   = all_ok && (position >= INDEX_BITS'(len_m1));
		m.start = position - INDEX_BITS'(len_m1);
	end

endmodule

// ===== hdl/sos_state.sv =====
// ----------------------------------------------------------------------------
// sos_state
// Running scan state: character window, position, non-overlapping count,
// skip counter, found flag, first and last start and the saturation flag.
// ----------------------------------------------------------------------------
module sos_state (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  sos_pkg::item_t               item,
	input  sos_pkg::match_t              m,
	input  logic [sos_pkg::PIDX_W-1:0]   len_m1,
	output sos_pkg::window_t             recent,
	output sos_pkg::index_t              position,
	output sos_pkg::result_t             summary
);
	import sos_pkg::*;

	window_t           recent_q;
	index_t            position_q;
	index_t            count_q;
	logic [PIDX_W-1:0] skip_q;
	index_t            first_q;
	index_t            last_q;
	logic              any_q;
	logic              ovf_q;
	logic              ovf_set;

	assign recent   = recent_q;
	assign position = position_q;

	// summary of the string so far
	always_comb begin
		summary.match_count = OUT_W'(count_q);
		summary.found       = any_q;
		summary.first_index = OUT_W'(first_q);
		summary.last_index  = OUT_W'(last_q);
		summary.saturated   = ovf_q;
	end

	// count or position blocked at its maximum
	always_comb begin
		ovf_set = ((skip_q == '0) && m.hit && (count_q == IDX_MAX)) ||
			(position_q == IDX_MAX);
	end

	// state update per word, end word clears the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			position_q <= '0;
			count_q    <= '0;
			skip_q     <= '0;
			first_q    <= '0;
			last_q     <= '0;
			any_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (adv) begin
			if (item.is_end) begin
				recent_q   <= '0;
				position_q <= '0;
				count_q    <= '0;
				skip_q     <= '0;
				first_q    <= '0;
				last_q     <= '0;
				any_q      <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				// window shift
				recent_q[0] <= item.ch;
				for (int k = 1; k < WIN_DEPTH; k++) begin
					recent_q[k] <= recent_q[k-1];
				end
				// overlapping first/last tracking
				if (m.hit) begin
					if (!any_q) begin
						first_q <= m.start;
					end
					last_q <= m.start;
					any_q  <= 1'b1;
				end
				// non-overlapping count with skip window
				if (skip_q != '0) begin
					skip_q <= skip_q - 1'b1;
				end else if (m.hit) begin
					if (count_q != IDX_MAX) begin
						count_q <= count_q + 1'b1;
					end
					skip_q <= len_m1;
				end
				// saturating position
				if (position_q != IDX_MAX) begin
					position_q <= position_q + 1'b1;
				end
				// sticky saturation flag
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/substring_occurrence_scan_top.sv =====
// An end word goes from the input register into the result register, waiting while that one is full.
// Throughput: one word per cycle; only an end word waits, on a full result register.
// The rate is set by the combinational window compare and the registered state update.
// Reset clears the scan state, the stage and result valid flags, and the
// configuration (pattern bytes zero, pattern length one).
// ----------------------------------------------------------------------------
// substring_occurrence_scan_top
// Streaming scanner that counts pattern occurrences in a byte string and
// reports a summary word at each end-of-string word.
// ----------------------------------------------------------------------------
module substring_occurrence_scan_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sos_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sos_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  sos_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output sos_pkg::result_t                 result
);
	import sos_pkg::*;

	pattern_t          pattern_q;
	logic [LEN_W-1:0]  plen_q;
	logic [PIDX_W-1:0] len_m1;

	logic              valid_s1;
	item_t             item_s1;
	logic              adv;

	window_t           recent;
	index_t            position;
	match_t            m;
	result_t           summary;

	logic              result_valid_q;
	result_t           result_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_BYTES:  pattern_q <= cfg_data;
				CFG_PATTERN_LENGTH: plen_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_m1 = eff_len_m1(plen_q);

	// stage 1 advances unless an end word meets a full result register
	assign adv        = valid_s1 && (!item_s1.is_end || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	sos_match u_match (
		.recent   (recent),
		.ch       (item_s1.ch),
		.pattern  (pattern_q),
		.len_m1   (len_m1),
		.position (position),
		.m        (m)
	);

	sos_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.m        (m),
		.len_m1   (len_m1),
		.recent   (recent),
		.position (position),
		.summary  (summary)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && item_s1.is_end) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.is_end) begin
			result_q <= summary;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// no match means an all-zero summary
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |->
		(result.match_count == '0 && result.first_index == '0 && result.last_index == '0))
		else $error("summary without a match is not zero");

	// the first match is always counted
	a_found_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> (result.match_count != '0))
		else $error("match found but count is zero");

	// first start never lies after last start
	a_first_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.first_index <= result.last_index))
		else $error("first index after last index");

	// a character word in stage 1 never stalls the input
	a_char_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.is_end) |-> item_ready)
		else $error("character word stalled the input");

endmodule

// ===== bench/substring_occurrence_scan_top_tb.sv =====
// ----------------------------------------------------------------------------
// substring_occurrence_scan_top_tb
// Self-checking bench for the substring occurrence scanner. A short table of
// hand-made strings opens the run, then random patterns and strings built
// mostly from pattern copies and pattern bytes. Table summary words are
// checked field by field against table values, random ones against a bench scan model.
// ----------------------------------------------------------------------------
module substring_occurrence_scan_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sos_pkg::*;

	localparam int DRAIN          = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_WORDS   = 1500;

	typedef enum {ROW_CFG, ROW_CHAR, ROW_END} row_kind_t;

	// one line of the directed table
	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    sel;
		logic [63:0] data;
		logic [7:0]  ch;
		bit          typed;
		result_t     want;
	} row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	// expected summary words, oldest first
	result_t summary_q [$];
	result_t head;
	int      fails       = 0;
	int      quiet_cycles = 0;
	int      ready_hold  = 0;
	bit      idle_on     = 1'b1;

	// scan model: configuration and running state
	logic [63:0] pat_reg = '0;
	logic [3:0]  len_reg = 4'd1;
	logic [7:0]  win [0:MAX_PATTERN-1];
	index_t      pos;
	index_t      cnt;
	index_t      first_at;
	index_t      last_at;
	logic [2:0]  skip;
	logic        any_hit;
	logic        sat_flag;

	substring_occurrence_scan_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pattern length in use, clamped to 1..MAX_PATTERN
	function automatic int span_of(input logic [3:0] len);
		if (len == 4'd0) return 1;
		if (int'(len) > MAX_PATTERN) return MAX_PATTERN;
		return int'(len);
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic clear_scan();
		foreach (win[i]) win[i] = '0;
		pos      = '0;
		cnt      = '0;
		first_at = '0;
		last_at  = '0;
		skip     = '0;
		any_hit  = 1'b0;
		sat_flag = 1'b0;
	endtask

	// advance the scan by one word; an end word yields the summary
	task automatic scan_word(input item_t w, output bit has, output result_t sum);
		int n;
		bit hit;
		has = 1'b0;
		sum = '0;
		if (w.is_end) begin
			sum.match_count = cnt;
			sum.found       = any_hit;
			sum.first_index = first_at;
			sum.last_index  = last_at;
			sum.saturated   = sat_flag;
			has = 1'b1;
			clear_scan();
			return;
		end
		n = span_of(len_reg);
		// newest character sits at index 0
		for (int i = MAX_PATTERN - 1; i > 0; i--) win[i] = win[i-1];
		win[0] = w.ch;
		hit = (int'(pos) + 1 >= n);
		for (int i = 0; i < n; i++) begin
			if (win[n-1-i] != pat_reg[8*i +: 8]) hit = 1'b0;
		end
		if (hit) begin
			if (!any_hit) first_at = index_t'(int'(pos) + 1 - n);
			last_at = index_t'(int'(pos) + 1 - n);
			any_hit = 1'b1;
		end
		// non-overlapping count: a counted match blocks the next n-1 characters
		if (skip != 3'd0) begin
			skip = skip - 3'd1;
		end else if (hit) begin
			if (cnt != IDX_MAX) cnt = cnt + 1'b1;
			else sat_flag = 1'b1;
			skip = 3'(n - 1);
		end
		if (pos != IDX_MAX) pos = pos + 1'b1;
		else sat_flag = 1'b1;
	endtask

	// send one word, then record what it should produce
	task automatic feed(input logic [7:0] c, input logic e, input bit typed,
			input result_t want);
		item_t   w;
		result_t sum;
		bit      has;
		int      gap;
		w.ch     = c;
		w.is_end = e;
		gap = idle_on ? pause_len() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
		scan_word(w, has, sum);
		if (has) summary_q.push_back(typed ? want : sum);
	endtask

	// wait until every summary is back and the pipeline has emptied
	task automatic settle();
		item_valid <= 1'b0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [63:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			CFG_PATTERN_BYTES:  pat_reg = d;
			CFG_PATTERN_LENGTH: len_reg = d[3:0];
			default: ;
		endcase
	endtask

	function automatic row_t cfg_row(input cfg_reg_t sel, input logic [63:0] d);
		row_t r;
		r.kind  = ROW_CFG;
		r.sel   = sel;
		r.data  = d;
		r.ch    = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic row_t char_row(input logic [7:0] c);
		row_t r;
		r      = cfg_row(CFG_PATTERN_BYTES, '0);
		r.kind = ROW_CHAR;
		r.ch   = c;
		return r;
	endfunction

	function automatic row_t end_row(input int n, input bit f, input int first,
			input int last, input bit s);
		row_t r;
		r                  = cfg_row(CFG_PATTERN_BYTES, '0);
		r.kind             = ROW_END;
		r.ch               = 8'h5a;
		r.typed            = 1'b1;
		r.want.match_count = OUT_W'(n);
		r.want.found       = f;
		r.want.first_index = OUT_W'(first);
		r.want.last_index  = OUT_W'(last);
		r.want.saturated   = s;
		return r;
	endfunction

	// result side stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			result_ready <= 1'b0;
			ready_hold--;
		end else begin
			result_ready <= 1'b1;
			if (idle_on) ready_hold = pause_len();
		end
	end

	// compare each summary word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (summary_q.size() == 0) begin
				$error("summary word with nothing expected");
				fails++;
			end else begin
				head = summary_q.pop_front();
				if (result.match_count !== head.match_count) begin
					$error("match_count: expected %0d, got %0d",
						head.match_count, result.match_count);
					fails++;
				end
				if (result.found !== head.found) begin
					$error("found: expected %0d, got %0d", head.found, result.found);
					fails++;
				end
				if (result.first_index !== head.first_index) begin
					$error("first_index: expected %0d, got %0d",
						head.first_index, result.first_index);
					fails++;
				end
				if (result.last_index !== head.last_index) begin
					$error("last_index: expected %0d, got %0d",
						head.last_index, result.last_index);
					fails++;
				end
				if (result.saturated !== head.saturated) begin
					$error("saturated: expected %0d, got %0d",
						head.saturated, result.saturated);
					fails++;
				end
			end
		end
	end

	// cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		row_t        plan [$];
		logic [7:0]  alpha [0:2];
		logic [63:0] pat;
		logic [63:0] d;
		logic [3:0]  plen;
		int          rand_words;
		int          n;
		int          nstr;
		int          slen;
		int          k;
		int          pick;

		clear_scan();
		plan = '{
			// empty string right after reset
			end_row(0, 0, 0, 0, 0),
			// reset pattern is a single zero byte
			char_row(8'h00), char_row(8'hff), char_row(8'h00),
			end_row(2, 1, 0, 2, 0),
			// length zero acts as one
			cfg_row(CFG_PATTERN_LENGTH, 64'h0),
			cfg_row(CFG_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff),
			char_row(8'hff), char_row(8'h12),
			end_row(1, 1, 0, 0, 0),
			// length above the maximum acts as eight; short prefix never matches
			cfg_row(CFG_PATTERN_LENGTH, 64'hf),
			char_row(8'hff), char_row(8'hff), char_row(8'hff),
			char_row(8'hff), char_row(8'hff), char_row(8'hff),
			char_row(8'hff), char_row(8'hff), char_row(8'hff),
			end_row(1, 1, 0, 1, 0),
			// overlapping vs non-overlapping matches
			cfg_row(CFG_PATTERN_BYTES, 64'h6161),
			cfg_row(CFG_PATTERN_LENGTH, 64'h2),
			char_row(8'h61), char_row(8'h61), char_row(8'h61),
			char_row(8'h61), char_row(8'h61),
			end_row(2, 1, 0, 3, 0)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					settle();
					write_reg(plan[i].sel, plan[i].data);
				end
				ROW_CHAR: feed(plan[i].ch, 1'b0, 1'b0, '0);
				ROW_END:  feed(plan[i].ch, 1'b1, plan[i].typed, plan[i].want);
				default: ;
			endcase
		end

		// random patterns, strings mostly assembled from pattern pieces
		rand_words = 0;
		while (rand_words < RANDOM_WORDS) begin
			settle();
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				plen = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
			end else begin
				plen = 4'($urandom_range(1, 8));
			end
			foreach (alpha[j]) alpha[j] = 8'($urandom);
			if ($urandom_range(0, 4) == 0) begin
				pat = {$urandom, $urandom};
			end else begin
				for (int j = 0; j < 8; j++) pat[8*j +: 8] = alpha[$urandom_range(0, 2)];
			end
			d = {$urandom, $urandom};
			d[3:0] = plen;
			write_reg(CFG_PATTERN_BYTES, pat);
			write_reg(CFG_PATTERN_LENGTH, d);
			n = span_of(plen);
			nstr = $urandom_range(1, 6);
			for (int s = 0; s < nstr; s++) begin
				slen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) :
					$urandom_range(0, 24);
				k = 0;
				while (k < slen) begin
					pick = $urandom_range(0, 9);
					if (pick < 5) begin
						for (int j = 0; j < n; j++) feed(pat[8*j +: 8], 1'b0, 1'b0, '0);
						k += n;
					end else if (pick < 9) begin
						feed(pat[8*$urandom_range(0, n - 1) +: 8], 1'b0, 1'b0, '0);
						k++;
					end else begin
						feed(8'($urandom), 1'b0, 1'b0, '0);
						k++;
					end
				end
				feed(8'($urandom), 1'b1, 1'b0, '0);
				rand_words += k + 1;
			end
		end

		settle();
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
